[design/c8alu_pkg.sv]
// Shared types and constants for the 8-bit ALU flag unit.
package c8alu_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned FuncW  = 4;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned FlagW  = 4;
  localparam int unsigned InDataW  = 16;  // operand + bit_index, byte padded
  localparam int unsigned OutDataW = 16;  // result_value + flag_nibble, byte padded
  localparam int unsigned OutUserW = 2;   // writes_operand_reg, writes_accumulator

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD = 4'd0,
    FUNC_SUB = 4'd1,
    FUNC_AND = 4'd2,
    FUNC_OR  = 4'd3,
    FUNC_XOR = 4'd4,
    FUNC_CP  = 4'd5,
    FUNC_INC = 4'd6,
    FUNC_DEC = 4'd7,
    FUNC_RL  = 4'd8,
    FUNC_RLA = 4'd9,
    FUNC_BIT = 4'd10,
    FUNC_CCF = 4'd11
  } func_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

endpackage

[design/cpu8_alu_flag_unit.sv]
// Top level: 8-bit ALU with accumulator and Z/N/H/C flags, stream in and out.
// One item per cycle sustained while the output is not stalled. An input
// register takes the item, the ALU and flag logic work on it against the
// accumulator and flags in one pass, and the result lands in an output
// register when the item leaves the input register, which waits while a
// result is stalled at the output. The accumulator and flags update as each
// item leaves the input register, so back-to-back items see the updated
// state. The input side keeps accepting while a result waits, until both
// the input and output registers are full. Reset clears accumulator and
// flags to zero. Opcodes 12 to 15 do nothing and report the accumulator.
module cpu8_alu_flag_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [c8alu_pkg::InDataW-1:0]         in_tdata,   // [7:0] operand, [10:8] bit_index
  input  logic [c8alu_pkg::FuncW-1:0]           in_tuser,   // [3:0] func
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [c8alu_pkg::OutDataW-1:0]        out_tdata,  // [7:0] result_value, [11:8] flag_nibble
  output logic [c8alu_pkg::OutUserW-1:0]        out_tuser   // [0] writes_operand_reg,
                                                            // [1] writes_accumulator
);
  import c8alu_pkg::*;

  // input stage
  logic               in_valid_r;
  logic [FuncW-1:0]   func_r;
  logic [DataW-1:0]   operand_r;
  logic [BitIdxW-1:0] bit_index_r;

  // architectural state
  logic [DataW-1:0]   acc_r, acc_nxt;
  flags_t             flags_r, flags_nxt;

  // output stage
  logic               out_valid_r;
  logic [DataW-1:0]   result_r, result_nxt;
  logic               wop_r, wop_nxt;
  logic               wacc_r, wacc_nxt;

  logic               advance;
  logic [DataW:0]     sum;
  logic [4:0]         nib_sum;
  logic [DataW-1:0]   logic_res;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign sum     = {1'b0, acc_r} + {1'b0, operand_r};
  assign nib_sum = {1'b0, acc_r[3:0]} + {1'b0, operand_r[3:0]};

  always_comb begin
    acc_nxt    = acc_r;
    flags_nxt  = flags_r;
    result_nxt = acc_r;
    wop_nxt    = 1'b0;
    wacc_nxt   = 1'b0;
    logic_res  = '0;
    case (func_t'(func_r))
      FUNC_ADD: begin
        result_nxt = sum[DataW-1:0];
        flags_nxt  = '{z: (sum[DataW-1:0] == '0), n: 1'b0, h: nib_sum[4], c: sum[DataW]};
        wacc_nxt   = 1'b1;
      end
      FUNC_SUB, FUNC_CP: begin
        logic_res = acc_r - operand_r;
        flags_nxt = '{z: (logic_res == '0), n: 1'b1,
                      h: (acc_r[3:0] < operand_r[3:0]), c: (acc_r < operand_r)};
        if (func_t'(func_r) == FUNC_SUB) begin
          result_nxt = logic_res;
          wacc_nxt   = 1'b1;
        end
      end
      FUNC_AND: begin
        logic_res  = acc_r & operand_r;
        result_nxt = logic_res;
        flags_nxt  = '{z: (logic_res == '0), n: 1'b0, h: 1'b1, c: 1'b0};
        wacc_nxt   = 1'b1;
      end
      FUNC_OR: begin
        logic_res  = acc_r | operand_r;
        result_nxt = logic_res;
        flags_nxt  = '{z: (logic_res == '0), n: 1'b0, h: 1'b0, c: 1'b0};
        wacc_nxt   = 1'b1;
      end
      FUNC_XOR: begin
        logic_res  = acc_r ^ operand_r;
        result_nxt = logic_res;
        flags_nxt  = '{z: (logic_res == '0), n: 1'b0, h: 1'b0, c: 1'b0};
        wacc_nxt   = 1'b1;
      end
      FUNC_INC: begin
        logic_res  = operand_r + DataW'(1);
        result_nxt = logic_res;
        flags_nxt  = '{z: (logic_res == '0), n: 1'b0, h: (operand_r[3:0] == 4'hF),
                       c: flags_r.c};
        wop_nxt    = 1'b1;
      end
      FUNC_DEC: begin
        logic_res  = operand_r - DataW'(1);
        result_nxt = logic_res;
        flags_nxt  = '{z: (logic_res == '0), n: 1'b1, h: (operand_r[3:0] == 4'h0),
                       c: flags_r.c};
        wop_nxt    = 1'b1;
      end
      FUNC_RL: begin
        logic_res  = {operand_r[DataW-2:0], flags_r.c};
        result_nxt = logic_res;
        flags_nxt  = '{z: (logic_res == '0), n: 1'b0, h: 1'b0, c: operand_r[DataW-1]};
        wop_nxt    = 1'b1;
      end
      FUNC_RLA: begin
        result_nxt = {acc_r[DataW-2:0], flags_r.c};
        flags_nxt  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_r[DataW-1]};
        wacc_nxt   = 1'b1;
      end
      FUNC_BIT: begin
        flags_nxt = '{z: !operand_r[bit_index_r], n: 1'b0, h: 1'b1, c: flags_r.c};
      end
      FUNC_CCF: begin
        flags_nxt = '{z: flags_r.z, n: 1'b0, h: 1'b0, c: !flags_r.c};
      end
      default: begin
        // unused opcodes: no change
      end
    endcase
    if (wacc_nxt) begin
      acc_nxt = result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      flags_r     <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        acc_r       <= acc_nxt;
        flags_r     <= flags_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      func_r      <= in_tuser;
      operand_r   <= in_tdata[DataW-1:0];
      bit_index_r <= in_tdata[DataW+BitIdxW-1:DataW];
    end
    if (advance) begin
      result_r <= result_nxt;
      wop_r    <= wop_nxt;
      wacc_r   <= wacc_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OutDataW-DataW-FlagW)'(0), flags_r, result_r};
  assign out_tuser  = {wacc_r, wop_r};

endmodule

[design/cpu8_alu_flag_unit_checker.sv]
// Port-level checker for the 8-bit ALU flag unit, bound to the top level.
module cpu8_alu_flag_unit_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [c8alu_pkg::OutDataW-1:0]        out_tdata,
  input logic [c8alu_pkg::OutUserW-1:0]        out_tuser
);
  import c8alu_pkg::*;

  // no result may appear right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // a result never targets both registers
  a_one_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("result targets both registers");

  // transfer into a stalled pipe fills it: input must back off while output stays stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && in_tvalid && in_tready
      |=> !(out_tvalid && !out_tready) || !in_tready)
    else $error("input accepted with both stages full");

endmodule

bind cpu8_alu_flag_unit cpu8_alu_flag_unit_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
